// ===== sv/firmware_packet_deframer_crc_check_unit_assert.svh =====
// Assertion macros shared by the deframer modules.
// Define ASSERT_OFF to compile the checks away.
`ifndef FIRMWARE_PACKET_DEFRAMER_CRC_CHECK_UNIT_ASSERT_SVH
`define FIRMWARE_PACKET_DEFRAMER_CRC_CHECK_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define FPDC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fpdc assertion failed");
`define FPDC_ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("fpdc forbidden condition seen");
`else
`define FPDC_ASSERT(name, clk, rst, prop)
`define FPDC_ASSERT_NEVER(name, clk, rst, expr)
`endif

`endif

// ===== sv/fpdc_pkg.sv =====
package fpdc_pkg;

   localparam int unsigned PAYLOAD_BYTES_DEFAULT = 128;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Frame phases.
   localparam logic [2:0] PH_WAIT  = 3'd0;
   localparam logic [2:0] PH_SEQ_H = 3'd1;
   localparam logic [2:0] PH_SEQ_L = 3'd2;
   localparam logic [2:0] PH_DATA  = 3'd3;
   localparam logic [2:0] PH_CRC_H = 3'd4;
   localparam logic [2:0] PH_CRC_L = 3'd5;

   // Result event codes.
   localparam logic [2:0] EV_DATA    = 3'd0;
   localparam logic [2:0] EV_GOOD    = 3'd1;
   localparam logic [2:0] EV_BAD     = 3'd2;
   localparam logic [2:0] EV_END     = 3'd3;
   localparam logic [2:0] EV_CANCEL  = 3'd4;
   localparam logic [2:0] EV_TIMEOUT = 3'd5;

   // Register indexes on the APB port (paddr[3:2]).
   localparam logic [1:0] REG_START   = 2'd0;
   localparam logic [1:0] REG_END     = 2'd1;
   localparam logic [1:0] REG_CANCEL  = 2'd2;
   localparam logic [1:0] REG_TIMEOUT = 2'd3;

   localparam int unsigned CSR_ADDR_W = 4;

   typedef struct packed {
      logic [7:0]  start_byte;
      logic [7:0]  end_byte;
      logic [7:0]  cancel_byte;
      logic [15:0] idle_timeout_ticks;
   } fpdc_cfg_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  payload_byte;
      logic [6:0]  byte_index;
      logic [15:0] seq_number;
      logic [15:0] received_crc;
      logic [15:0] computed_crc;
   } fpdc_result_type;

   typedef struct packed {
      logic            valid;
      fpdc_result_type data;
   } fpdc_push_type;

   // One byte through CRC-16/XMODEM, MSB first.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/fpdc_if.sv =====
interface fpdc_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface fpdc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [7:0]  payload_byte;
   logic [6:0]  byte_index;
   logic [15:0] seq_number;
   logic [15:0] received_crc;
   logic [15:0] computed_crc;

   modport source (output valid, output event_res, output payload_byte, output byte_index,
                   output seq_number, output received_crc, output computed_crc,
                   input ready);
   modport sink   (input valid, input event_res, input payload_byte, input byte_index,
                   input seq_number, input received_crc, input computed_crc,
                   output ready);
endinterface

// ===== sv/fpdc_csr.sv =====
module fpdc_csr import fpdc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output fpdc_cfg_type          cfg
);

   fpdc_cfg_type cfg_ff, cfg_in;
   logic         wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_START:   cfg_in.start_byte         = pwdata[7:0];
            REG_END:     cfg_in.end_byte           = pwdata[7:0];
            REG_CANCEL:  cfg_in.cancel_byte        = pwdata[7:0];
            REG_TIMEOUT: cfg_in.idle_timeout_ticks = pwdata[15:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_START:   prdata = {24'h0, cfg_ff.start_byte};
         REG_END:     prdata = {24'h0, cfg_ff.end_byte};
         REG_CANCEL:  prdata = {24'h0, cfg_ff.cancel_byte};
         REG_TIMEOUT: prdata = {16'h0, cfg_ff.idle_timeout_ticks};
         default:     prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte         <= 8'd2;
         cfg_ff.end_byte           <= 8'd4;
         cfg_ff.cancel_byte        <= 8'd24;
         cfg_ff.idle_timeout_ticks <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/fpdc_core.sv =====
`include "firmware_packet_deframer_crc_check_unit_assert.svh"

module fpdc_core import fpdc_pkg::*; #(
   parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_func,
   input  logic [7:0]    req_rx_byte,
   output logic          req_ready,
   input  fpdc_cfg_type  cfg,
   input  logic          can_take,
   output fpdc_push_type push
);

   localparam int unsigned CW = $clog2(PAYLOAD_BYTES + 1);

   // Input register.
   logic        in_v_ff, in_v_in;
   logic        func_ff;
   logic [7:0]  byte_ff;

   // Deframer state.
   logic [2:0]    phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   seq_ff, seq_in;
   logic [7:0]    crch_ff, crch_in;
   logic [15:0]   crc_ff, crc_in;
   logic [15:0]   idle_ff, idle_in;

   logic          fire;
   logic [15:0]   idle_inc;
   logic [15:0]   crc_next;
   logic [CW-1:0] count_inc;
   logic [15:0]   rcrc;

   assign fire      = in_v_ff && can_take;
   assign req_ready = !in_v_ff || fire;
   assign in_v_in   = req_valid ? 1'b1 : (in_v_ff && !fire);

   assign idle_inc  = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
   assign crc_next  = crc_feed(crc_ff, byte_ff);
   assign count_inc = count_ff + CW'(1);
   assign rcrc      = {crch_ff, byte_ff};

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      seq_in     = seq_ff;
      crch_in    = crch_ff;
      crc_in     = crc_ff;
      idle_in    = idle_ff;
      push.valid = 1'b0;
      push.data  = '0;
      if (fire) begin
         if (func_ff) begin
            if (idle_inc >= cfg.idle_timeout_ticks) begin
               idle_in              = 16'd0;
               phase_in             = PH_WAIT;
               push.valid           = 1'b1;
               push.data.event_res  = EV_TIMEOUT;
            end else begin
               idle_in = idle_inc;
            end
         end else begin
            idle_in = 16'd0;
            unique case (phase_ff)
               PH_SEQ_H: begin
                  seq_in   = {byte_ff, 8'h00};
                  phase_in = PH_SEQ_L;
               end
               PH_SEQ_L: begin
                  seq_in   = {seq_ff[15:8], byte_ff};
                  phase_in = PH_DATA;
               end
               PH_DATA: begin
                  crc_in                 = crc_next;
                  count_in               = count_inc;
                  push.valid             = 1'b1;
                  push.data.event_res    = EV_DATA;
                  push.data.payload_byte = byte_ff;
                  push.data.byte_index   = 7'(count_ff);
                  push.data.seq_number   = seq_ff;
                  push.data.computed_crc = crc_next;
                  if (count_inc >= CW'(PAYLOAD_BYTES)) begin
                     phase_in = PH_CRC_H;
                  end
               end
               PH_CRC_H: begin
                  crch_in  = byte_ff;
                  phase_in = PH_CRC_L;
               end
               PH_CRC_L: begin
                  phase_in               = PH_WAIT;
                  push.valid             = 1'b1;
                  push.data.event_res    = (rcrc == crc_ff) ? EV_GOOD : EV_BAD;
                  push.data.seq_number   = seq_ff;
                  push.data.received_crc = rcrc;
                  push.data.computed_crc = crc_ff;
               end
               default: begin
                  // Waiting, and any unused phase code behaves the same.
                  phase_in = PH_WAIT;
                  if (byte_ff == cfg.start_byte) begin
                     phase_in = PH_SEQ_H;
                     count_in = '0;
                     seq_in   = 16'd0;
                     crch_in  = 8'd0;
                     crc_in   = 16'd0;
                  end else if (byte_ff == cfg.end_byte) begin
                     push.valid          = 1'b1;
                     push.data.event_res = EV_END;
                  end else if (byte_ff == cfg.cancel_byte) begin
                     push.valid          = 1'b1;
                     push.data.event_res = EV_CANCEL;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         phase_ff <= PH_WAIT;
         count_ff <= '0;
         seq_ff   <= 16'd0;
         crch_ff  <= 8'd0;
         crc_ff   <= 16'd0;
         idle_ff  <= 16'd0;
      end else begin
         in_v_ff  <= in_v_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         seq_ff   <= seq_in;
         crch_ff  <= crch_in;
         crc_ff   <= crc_in;
         idle_ff  <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff <= req_func;
         byte_ff <= req_rx_byte;
      end
   end

   `FPDC_ASSERT_NEVER(a_count_in_range, clock, reset, count_ff > CW'(PAYLOAD_BYTES))
   `FPDC_ASSERT(a_timeout_resyncs, clock, reset,
      push.valid && push.data.event_res == EV_TIMEOUT |=> phase_ff == PH_WAIT && idle_ff == 16'd0)
   `FPDC_ASSERT(a_last_payload_to_crc, clock, reset,
      push.valid && push.data.event_res == EV_DATA && count_inc == CW'(PAYLOAD_BYTES) |=> phase_ff == PH_CRC_H)

endmodule

// ===== sv/fpdc_out_buf.sv =====
`include "firmware_packet_deframer_crc_check_unit_assert.svh"

module fpdc_out_buf import fpdc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  fpdc_push_type   push,
   output logic            can_take,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output fpdc_result_type rsp_data
);

   // Two entries: the head drives the output, the skid entry catches a
   // result that arrives while the head is stalled.
   logic            head_v_ff, head_v_in;
   logic            skid_v_ff, skid_v_in;
   fpdc_result_type head_ff, head_in;
   fpdc_result_type skid_ff, skid_in;
   logic            pop;

   assign pop       = head_v_ff && rsp_ready;
   assign can_take  = !(head_v_ff && skid_v_ff) || pop;
   assign rsp_valid = head_v_ff;
   assign rsp_data  = head_ff;

   always_comb begin
      head_v_in = head_v_ff;
      skid_v_in = skid_v_ff;
      head_in   = head_ff;
      skid_in   = skid_ff;
      if (pop) begin
         head_in   = skid_ff;
         head_v_in = skid_v_ff;
         skid_v_in = 1'b0;
      end
      if (push.valid) begin
         if (!head_v_in) begin
            head_in   = push.data;
            head_v_in = 1'b1;
         end else begin
            skid_in   = push.data;
            skid_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         head_v_ff <= head_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   `FPDC_ASSERT_NEVER(a_skid_needs_head, clock, reset, skid_v_ff && !head_v_ff)
   `FPDC_ASSERT_NEVER(a_no_overflow, clock, reset, push.valid && head_v_ff && skid_v_ff && !pop)
   `FPDC_ASSERT(a_skid_moves_up, clock, reset,
      head_v_ff && skid_v_ff && pop |=> head_v_ff && head_ff == $past(skid_ff))

endmodule

// ===== sv/firmware_packet_deframer_crc_check_unit.sv =====
// Channel   Direction  Handshake      Carries
// req_chan  in         valid/ready    func (byte or timer tick), rx_byte
// rsp_chan  out        valid/ready    event_res, payload_byte, byte_index,
//                                     seq_number, received_crc, computed_crc
// APB       in/out     psel/penable   start/end/cancel bytes, idle timeout
//
// An item is latched into an input register; once the result buffer has room, one pass of logic
// (phase decode plus an eight-step CRC-16 update) writes its result, if any, into a
// two-entry result buffer, whose head register drives it on rsp_chan. One item per cycle
// is sustained while rsp_chan takes results. Reset is synchronous and active high.
// req_chan.ready drops only while the input register holds an item and both result
// entries are full with rsp_chan stalled.
module firmware_packet_deframer_crc_check_unit import fpdc_pkg::*; #(
   parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   fpdc_req_if.sink              req_chan,
   fpdc_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   fpdc_cfg_type    cfg;
   fpdc_push_type   push;
   fpdc_result_type rsp_data;
   logic            can_take;

   // Configuration registers; written only while the block is idle, which the user must ensure.
   fpdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Frame state machine and running CRC. It produces at most one result
   // per item and only advances when the result buffer has room.
   fpdc_core #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_func    (req_chan.func),
      .req_rx_byte (req_chan.rx_byte),
      .req_ready   (req_chan.ready),
      .cfg         (cfg),
      .can_take    (can_take),
      .push        (push)
   );

   // Result register with a skid entry behind it.
   fpdc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .can_take  (can_take),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_chan.event_res    = rsp_data.event_res;
   assign rsp_chan.payload_byte = rsp_data.payload_byte;
   assign rsp_chan.byte_index   = rsp_data.byte_index;
   assign rsp_chan.seq_number   = rsp_data.seq_number;
   assign rsp_chan.received_crc = rsp_data.received_crc;
   assign rsp_chan.computed_crc = rsp_data.computed_crc;

endmodule
